FILE: sv/vang_pkg.sv
// ----------------------------------------------------------------------------
// vang_pkg: shared types and constants for the vector angle block
// Fixed-point constants, the CORDIC arctangent table and flag types.
// ----------------------------------------------------------------------------
package vang_pkg;

   // fraction bits of the internal cosine / angle format (Q2.30)
   localparam int CFRAC = 30;
   // signed width of the CORDIC x, y and z datapath
   localparam int CORDIC_W = 34;
   // pi in Q2.30
   localparam logic [31:0] PI_Q30 = 32'd3373259426;
   // table length of the arctangent constants
   localparam int ATAN_ENTRIES = 32;

   // flags that travel with an item down the pipeline
   typedef struct packed {
      logic undef;   // zero-length vector seen
      logic neg;     // dot product below zero
   } vang_flags_type;

   localparam int FLAGS_W = $bits(vang_flags_type);

   // floor(atan(2^-i) * 2^30)
   function automatic logic [31:0] atan_q30(input logic [4:0] idx);
      logic [31:0] val;
      unique case (idx)
         5'd0:  val = 32'h3243F6A8;
         5'd1:  val = 32'h1DAC6705;
         5'd2:  val = 32'h0FADBAFC;
         5'd3:  val = 32'h07F56EA6;
         5'd4:  val = 32'h03FEAB76;
         5'd5:  val = 32'h01FFD55B;
         5'd6:  val = 32'h00FFFAAA;
         5'd7:  val = 32'h007FFF55;
         5'd8:  val = 32'h003FFFEA;
         5'd9:  val = 32'h001FFFFD;
         5'd10: val = 32'h000FFFFF;
         5'd11: val = 32'h0007FFFF;
         5'd12: val = 32'h0003FFFF;
         5'd13: val = 32'h0001FFFF;
         5'd14: val = 32'h0000FFFF;
         5'd15: val = 32'h00007FFF;
         5'd16: val = 32'h00003FFF;
         5'd17: val = 32'h00001FFF;
         5'd18: val = 32'h00000FFF;
         5'd19: val = 32'h000007FF;
         5'd20: val = 32'h000003FF;
         5'd21: val = 32'h000001FF;
         5'd22: val = 32'h000000FF;
         5'd23: val = 32'h0000007F;
         5'd24: val = 32'h0000003F;
         5'd25: val = 32'h0000001F;
         5'd26: val = 32'h0000000F;
         5'd27: val = 32'h00000007;
         5'd28: val = 32'h00000003;
         5'd29: val = 32'h00000001;
         5'd30: val = 32'h00000000;
         5'd31: val = 32'h00000000;
      endcase
      return val;
   endfunction

endpackage

FILE: sv/vang_lane.sv
// ----------------------------------------------------------------------------
// vang_lane: per-axis product lane
// Forms a*b, a*a and b*b for one vector component pair, registered.
// ----------------------------------------------------------------------------
module vang_lane #(
   parameter int CB = 16
) (
   input  logic                 clock,
   input  logic signed [CB-1:0] a,
   input  logic signed [CB-1:0] b,
   output logic signed [2*CB-1:0] ab,
   output logic [2*CB-1:0]      aa,
   output logic [2*CB-1:0]      bb
);

   logic signed [2*CB-1:0] ab_ff;
   logic signed [2*CB-1:0] aa_ff;
   logic signed [2*CB-1:0] bb_ff;

   // three products per lane, payload only
   always_ff @(posedge clock) begin
      ab_ff <= a * b;
      aa_ff <= a * a;
      bb_ff <= b * b;
   end

   assign ab = ab_ff;
   assign aa = unsigned'(aa_ff);
   assign bb = unsigned'(bb_ff);

endmodule

FILE: sv/vang_sqrt.sv
// ----------------------------------------------------------------------------
// vang_sqrt: pipelined integer square root
// One root bit per stage, restoring method on the running remainder.
// ----------------------------------------------------------------------------
module vang_sqrt #(
   parameter int IW = 64,
   parameter int RW = 32,
   parameter int SW = 2
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [IW-1:0] in_value,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [RW-1:0] out_root,
   output logic [SW-1:0] out_side
);

   localparam int TW = 2 * RW + 2;

   logic [TW-1:0] rem_ff  [RW];
   logic [RW-1:0] root_ff [RW];
   logic [SW-1:0] side_ff [RW];
   logic          valid_ff[RW];

   for (genvar s = 0; s < RW; s++) begin : g_stage
      localparam int J = RW - 1 - s;
      logic [TW-1:0] rem_src;
      logic [RW-1:0] root_src;
      logic [SW-1:0] side_src;
      logic          valid_src;
      logic [TW-1:0] trial;
      logic [TW-1:0] rem_in;
      logic [RW-1:0] root_in;

      if (s == 0) begin : g_first
         assign rem_src   = TW'(in_value);
         assign root_src  = '0;
         assign side_src  = in_side;
         assign valid_src = in_valid;
      end else begin : g_next
         assign rem_src   = rem_ff[s-1];
         assign root_src  = root_ff[s-1];
         assign side_src  = side_ff[s-1];
         assign valid_src = valid_ff[s-1];
      end

      // try setting root bit J: cost is 2*r*2^J + 4^J
      always_comb begin
         trial = (TW'(root_src) << (J + 1)) + (TW'(1) << (2 * J));
         if (rem_src >= trial) begin
            rem_in  = rem_src - trial;
            root_in = root_src | (RW'(1) << J);
         end else begin
            rem_in  = rem_src;
            root_in = root_src;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else begin
            valid_ff[s] <= valid_src;
         end
         rem_ff[s]  <= rem_in;
         root_ff[s] <= root_in;
         side_ff[s] <= side_src;
      end
   end

   assign out_valid = valid_ff[RW-1];
   assign out_root  = root_ff[RW-1];
   assign out_side  = side_ff[RW-1];

endmodule

FILE: sv/vang_div.sv
// ----------------------------------------------------------------------------
// vang_div: pipelined restoring divider
// One quotient bit per stage; the numerator is below den * 2^QW.
// ----------------------------------------------------------------------------
module vang_div #(
   parameter int NW = 63,
   parameter int DW = 32,
   parameter int QW = 31,
   parameter int SW = 2
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [NW-1:0] in_num,
   input  logic [DW-1:0] in_den,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [QW-1:0] out_quo,
   output logic [SW-1:0] out_side
);

   logic [NW-1:0] rem_ff  [QW];
   logic [DW-1:0] den_ff  [QW];
   logic [QW-1:0] quo_ff  [QW];
   logic [SW-1:0] side_ff [QW];
   logic          valid_ff[QW];

   for (genvar s = 0; s < QW; s++) begin : g_stage
      localparam int K = QW - 1 - s;
      logic [NW-1:0] rem_src;
      logic [DW-1:0] den_src;
      logic [QW-1:0] quo_src;
      logic [SW-1:0] side_src;
      logic          valid_src;
      logic [NW-1:0] dsh;
      logic [NW-1:0] rem_in;
      logic [QW-1:0] quo_in;

      if (s == 0) begin : g_first
         assign rem_src   = in_num;
         assign den_src   = in_den;
         assign quo_src   = '0;
         assign side_src  = in_side;
         assign valid_src = in_valid;
      end else begin : g_next
         assign rem_src   = rem_ff[s-1];
         assign den_src   = den_ff[s-1];
         assign quo_src   = quo_ff[s-1];
         assign side_src  = side_ff[s-1];
         assign valid_src = valid_ff[s-1];
      end

      // compare against the shifted divisor, subtract on success
      always_comb begin
         dsh = NW'(den_src) << K;
         if (rem_src >= dsh) begin
            rem_in = rem_src - dsh;
            quo_in = quo_src | (QW'(1) << K);
         end else begin
            rem_in = rem_src;
            quo_in = quo_src;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else begin
            valid_ff[s] <= valid_src;
         end
         rem_ff[s]  <= rem_in;
         den_ff[s]  <= den_src;
         quo_ff[s]  <= quo_in;
         side_ff[s] <= side_src;
      end
   end

   assign out_valid = valid_ff[QW-1];
   assign out_quo   = quo_ff[QW-1];
   assign out_side  = side_ff[QW-1];

endmodule

FILE: sv/vang_cordic.sv
// ----------------------------------------------------------------------------
// vang_cordic: pipelined CORDIC in vectoring mode
// Rotates (x, y) onto the x axis, one micro-rotation per stage, summing z.
// ----------------------------------------------------------------------------
module vang_cordic
   import vang_pkg::*;
#(
   parameter int N  = 16,
   parameter int SW = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic signed [CORDIC_W-1:0] in_x,
   input  logic signed [CORDIC_W-1:0] in_y,
   input  logic [SW-1:0]              in_side,
   output logic                       out_valid,
   output logic signed [CORDIC_W-1:0] out_z,
   output logic [SW-1:0]              out_side
);

   logic signed [CORDIC_W-1:0] x_ff   [N];
   logic signed [CORDIC_W-1:0] y_ff   [N];
   logic signed [CORDIC_W-1:0] z_ff   [N];
   logic [SW-1:0]              side_ff[N];
   logic                       valid_ff[N];

   for (genvar s = 0; s < N; s++) begin : g_stage
      logic signed [CORDIC_W-1:0] x_src;
      logic signed [CORDIC_W-1:0] y_src;
      logic signed [CORDIC_W-1:0] z_src;
      logic [SW-1:0]              side_src;
      logic                       valid_src;
      logic signed [CORDIC_W-1:0] xs;
      logic signed [CORDIC_W-1:0] ys;
      logic signed [CORDIC_W-1:0] ang;
      logic signed [CORDIC_W-1:0] x_in;
      logic signed [CORDIC_W-1:0] y_in;
      logic signed [CORDIC_W-1:0] z_in;

      if (s == 0) begin : g_first
         assign x_src     = in_x;
         assign y_src     = in_y;
         assign z_src     = '0;
         assign side_src  = in_side;
         assign valid_src = in_valid;
      end else begin : g_next
         assign x_src     = x_ff[s-1];
         assign y_src     = y_ff[s-1];
         assign z_src     = z_ff[s-1];
         assign side_src  = side_ff[s-1];
         assign valid_src = valid_ff[s-1];
      end

      // rotate toward the x axis by atan(2^-s)
      always_comb begin
         xs  = x_src >>> s;
         ys  = y_src >>> s;
         ang = signed'(CORDIC_W'(atan_q30(5'(s))));
         if (y_src > 0) begin
            x_in = x_src + ys;
            y_in = y_src - xs;
            z_in = z_src + ang;
         end else begin
            x_in = x_src - ys;
            y_in = y_src + xs;
            z_in = z_src - ang;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else begin
            valid_ff[s] <= valid_src;
         end
         x_ff[s]    <= x_in;
         y_ff[s]    <= y_in;
         z_ff[s]    <= z_in;
         side_ff[s] <= side_src;
      end
   end

   assign out_valid = valid_ff[N-1];
   assign out_z     = z_ff[N-1];
   assign out_side  = side_ff[N-1];

endmodule

FILE: sv/vector_angle_3d.sv
// ----------------------------------------------------------------------------
// vector_angle_3d: angle between two 3D vectors
// Fully pipelined arc cosine of the normalized dot product.
// ----------------------------------------------------------------------------
// Usage:
//   An item transfers at a rising edge with start high and busy low. busy is
//   always low: the pipeline takes one vector pair every cycle.
//   Each result appears for one cycle with rsp_valid high; the receiver
//   cannot stall, so results are never held.
//   From request to result an item passes three product lanes, a merge
//   stage, the magnitude product, a 2*COMPONENT_BITS-stage square root, a
//   31-stage divider, the cosine square, a 31-stage square root for the
//   sine, one CORDIC stage per iteration and the output register.
//   Throughput is one item per cycle, set by the fully staged units.
//   A zero-length vector gives rsp_undefined high and rsp_angle zero.
//   Reset clears every valid bit; items in flight are dropped.
// ----------------------------------------------------------------------------
module vector_angle_3d
   import vang_pkg::*;
#(
   parameter int COMPONENT_BITS      = 16,
   parameter int ANGLE_FRACTION_BITS = 14,
   parameter int ARCCOS_ITERATIONS   = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic signed [COMPONENT_BITS-1:0] req_a_x,
   input  logic signed [COMPONENT_BITS-1:0] req_a_y,
   input  logic signed [COMPONENT_BITS-1:0] req_a_z,
   input  logic signed [COMPONENT_BITS-1:0] req_b_x,
   input  logic signed [COMPONENT_BITS-1:0] req_b_y,
   input  logic signed [COMPONENT_BITS-1:0] req_b_z,
   output logic                             rsp_valid,
   output logic [15:0]                      rsp_angle,
   output logic                             rsp_undefined
);

   localparam int CB    = COMPONENT_BITS;
   localparam int MW    = 2 * CB;
   localparam int PW    = 4 * CB;
   localparam int NW    = MW + CFRAC + 1;
   localparam int QW    = CFRAC + 1;
   localparam int SIW   = 2 * CFRAC + 1;
   localparam int STEPS = (ARCCOS_ITERATIONS > ATAN_ENTRIES) ? ATAN_ENTRIES
                                                              : ARCCOS_ITERATIONS;
   localparam int ZW    = CORDIC_W + 1;
   localparam int SHIFT = CFRAC - ANGLE_FRACTION_BITS;
   localparam logic [QW-1:0] ONE_Q = QW'(1) << CFRAC;

   assign busy = 1'b0;

   // ---------------- product lanes ----------------
   logic signed [MW-1:0] ab [3];
   logic [MW-1:0]        aa [3];
   logic [MW-1:0]        bb [3];
   logic signed [CB-1:0] lane_a [3];
   logic signed [CB-1:0] lane_b [3];

   assign lane_a[0] = req_a_x;
   assign lane_a[1] = req_a_y;
   assign lane_a[2] = req_a_z;
   assign lane_b[0] = req_b_x;
   assign lane_b[1] = req_b_y;
   assign lane_b[2] = req_b_z;

   for (genvar l = 0; l < 3; l++) begin : g_lane
      vang_lane #(.CB(CB)) u_lane (
         .clock (clock),
         .a     (lane_a[l]),
         .b     (lane_b[l]),
         .ab    (ab[l]),
         .aa    (aa[l]),
         .bb    (bb[l])
      );
   end

   logic v0_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else begin
         v0_ff <= start & ~busy;
      end
   end

   // ---------------- merge: dot product and squared magnitudes ----------------
   logic signed [MW+1:0] dot_ff;
   logic [MW-1:0]        ma2_ff;
   logic [MW-1:0]        mb2_ff;
   logic                 v1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= v0_ff;
      end
      dot_ff <= (MW+2)'(ab[0]) + (MW+2)'(ab[1]) + (MW+2)'(ab[2]);
      ma2_ff <= aa[0] + aa[1] + aa[2];
      mb2_ff <= bb[0] + bb[1] + bb[2];
   end

   // ---------------- magnitude product, sign and zero check ----------------
   logic [PW-1:0]        prod_ff;
   logic [MW-1:0]        mag_ff;
   vang_flags_type       fl2_ff;
   logic                 v2_ff;
   logic signed [MW+1:0] dot_abs;

   assign dot_abs = (dot_ff < 0) ? -dot_ff : dot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      prod_ff      <= PW'(ma2_ff) * PW'(mb2_ff);
      mag_ff       <= dot_abs[MW-1:0];
      fl2_ff.undef <= (ma2_ff == '0) || (mb2_ff == '0);
      fl2_ff.neg   <= dot_ff < 0;
   end

   // ---------------- denominator square root ----------------
   logic                    v3;
   logic [MW-1:0]           den;
   logic [FLAGS_W+MW-1:0]   side3;
   vang_flags_type          fl3;
   logic [MW-1:0]           mag3;

   vang_sqrt #(.IW(PW), .RW(MW), .SW(FLAGS_W + MW)) u_sqrt_den (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v2_ff),
      .in_value  (prod_ff),
      .in_side   ({fl2_ff, mag_ff}),
      .out_valid (v3),
      .out_root  (den),
      .out_side  (side3)
   );

   assign fl3  = side3[FLAGS_W+MW-1:MW];
   assign mag3 = side3[MW-1:0];

   // ---------------- cosine division with rounding ----------------
   logic          v4;
   logic [QW-1:0] quo;
   logic [NW-1:0] num;
   vang_flags_type fl4;

   assign num = (NW'(mag3) << CFRAC) + NW'(den >> 1);

   vang_div #(.NW(NW), .DW(MW), .QW(QW), .SW(FLAGS_W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v3),
      .in_num    (num),
      .in_den    (den),
      .in_side   (fl3),
      .out_valid (v4),
      .out_quo   (quo),
      .out_side  (fl4)
   );

   // ---------------- clamp and square the cosine ----------------
   logic [QW-1:0]   q_clamp;
   logic [QW-1:0]   q5_ff;
   logic [2*QW-1:0] qsq5_ff;
   vang_flags_type  fl5_ff;
   logic            v5_ff;

   assign q_clamp = (quo > ONE_Q) ? ONE_Q : quo;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else begin
         v5_ff <= v4;
      end
      q5_ff   <= q_clamp;
      qsq5_ff <= (2*QW)'(q_clamp) * (2*QW)'(q_clamp);
      fl5_ff  <= fl4;
   end

   // ---------------- sine square root ----------------
   logic [SIW-1:0]        one_minus;
   logic                  v6;
   logic [QW-1:0]         sine;
   logic [FLAGS_W+QW-1:0] side6;
   vang_flags_type        fl6;
   logic [QW-1:0]         q6;

   assign one_minus = (SIW'(1) << (2 * CFRAC)) - SIW'(qsq5_ff);

   vang_sqrt #(.IW(SIW), .RW(QW), .SW(FLAGS_W + QW)) u_sqrt_sin (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v5_ff),
      .in_value  (one_minus),
      .in_side   ({fl5_ff, q5_ff}),
      .out_valid (v6),
      .out_root  (sine),
      .out_side  (side6)
   );

   assign fl6 = side6[FLAGS_W+QW-1:QW];
   assign q6  = side6[QW-1:0];

   // ---------------- arc tangent by CORDIC ----------------
   logic                       v7;
   logic signed [CORDIC_W-1:0] z7;
   vang_flags_type             fl7;

   vang_cordic #(.N(STEPS), .SW(FLAGS_W)) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v6),
      .in_x      (signed'(CORDIC_W'(q6))),
      .in_y      (signed'(CORDIC_W'(sine))),
      .in_side   (fl6),
      .out_valid (v7),
      .out_z     (z7),
      .out_side  (fl7)
   );

   // ---------------- reflect, clamp, round to output ----------------
   logic signed [ZW-1:0] pi_z;
   logic signed [ZW-1:0] z_ref;
   logic signed [ZW-1:0] z_clp;
   logic signed [ZW-1:0] z_rnd;
   logic [15:0]          angle_in;
   logic                 rsp_valid_ff;
   logic [15:0]          angle_ff;
   logic                 undef_ff;

   assign pi_z = signed'(ZW'(PI_Q30));

   always_comb begin
      z_ref = fl7.neg ? (pi_z - ZW'(z7)) : ZW'(z7);
      if (z_ref < 0) begin
         z_clp = '0;
      end else if (z_ref > pi_z) begin
         z_clp = pi_z;
      end else begin
         z_clp = z_ref;
      end
      z_rnd    = z_clp + (ZW'(1) << (SHIFT - 1));
      angle_in = 16'(z_rnd >>> SHIFT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= v7;
      end
      angle_ff <= fl7.undef ? 16'd0 : angle_in;
      undef_ff <= fl7.undef;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_angle     = angle_ff;
   assign rsp_undefined = undef_ff;

   // ---------------- assertions ----------------
   a_undef_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_undefined) |-> (rsp_angle == 16'd0))
      else $error("undefined result with nonzero angle");

   a_reset_flush: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result strobe after reset");

   a_zero_prod: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && !fl2_ff.undef) |-> (prod_ff != '0))
      else $error("nonzero magnitudes gave zero product");

endmodule

FILE: verif/tb_vector_angle_3d.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vector_angle_3d: self-checking bench for the 3D vector angle block
// Directed and random vector pairs are driven through the command port. A
// bit-exact angle predictor fills a queue of expected angles, and every
// response strobe is compared with the oldest entry.
// ----------------------------------------------------------------------------
module tb_vector_angle_3d;
   import vang_pkg::*;

   localparam int CB    = 16;
   localparam int FRAC  = 14;
   localparam int ITERS = 16;
   localparam int LATENCY = 5 + 2*CB + 62 + ITERS;

   typedef struct {
      logic signed [CB-1:0] ax, ay, az, bx, by, bz;
   } vec_pair_type;

   typedef struct {
      logic [15:0] angle;
      logic        undef;
   } angle_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [CB-1:0] req_a_x = '0, req_a_y = '0, req_a_z = '0;
   logic signed [CB-1:0] req_b_x = '0, req_b_y = '0, req_b_z = '0;
   logic rsp_valid;
   logic [15:0] rsp_angle;
   logic rsp_undefined;

   vec_pair_type pending_pairs[$];
   angle_type    expected_angles[$];
   int           errors = 0;
   int           quiet_left = 0;
   bit           stim_done = 1'b0;
   bit           drain_hold = 1'b0;

   vector_angle_3d #(
      .COMPONENT_BITS(CB), .ANGLE_FRACTION_BITS(FRAC), .ARCCOS_ITERATIONS(ITERS)
   ) i_dut (
      .clock, .reset, .start, .busy,
      .req_a_x, .req_a_y, .req_a_z, .req_b_x, .req_b_y, .req_b_z,
      .rsp_valid, .rsp_angle, .rsp_undefined
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // bit-serial floor square root
   function automatic logic [63:0] int_sqrt(input logic [63:0] v);
      logic [63:0] r, bit_w;
      r = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > v) bit_w >>= 2;
      while (bit_w != 0) begin
         if (v >= r + bit_w) begin
            v = v - (r + bit_w);
            r = (r >> 1) + bit_w;
         end else begin
            r = r >> 1;
         end
         bit_w >>= 2;
      end
      return r;
   endfunction

   // expected angle for one vector pair
   function automatic angle_type predict_angle(input vec_pair_type p);
      angle_type res;
      longint dot, x, y, z, xs, ys;
      logic [63:0] ma2, mb2, den, mag, q;
      bit neg;
      dot = p.ax*p.bx + p.ay*p.by + p.az*p.bz;
      ma2 = p.ax*p.ax + p.ay*p.ay + p.az*p.az;
      mb2 = p.bx*p.bx + p.by*p.by + p.bz*p.bz;
      if (ma2 == 0 || mb2 == 0) begin
         res.angle = '0;
         res.undef = 1'b1;
         return res;
      end
      den = int_sqrt(ma2 * mb2);
      neg = dot < 0;
      mag = neg ? -dot : dot;
      q = ((mag << 30) + (den >> 1)) / den;
      if (q > (64'd1 << 30)) q = 64'd1 << 30;
      x = q;
      y = int_sqrt((64'd1 << 60) - q*q);
      z = 0;
      for (int i = 0; i < ITERS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x += ys; y -= xs; z += atan_q30(i[4:0]);
         end else begin
            x -= ys; y += xs; z -= atan_q30(i[4:0]);
         end
      end
      if (neg) z = longint'(PI_Q30) - z;
      if (z < 0) z = 0;
      if (z > longint'(PI_Q30)) z = PI_Q30;
      res.angle = 16'((z + (64'd1 << (29 - FRAC))) >> (30 - FRAC));
      res.undef = 1'b0;
      return res;
   endfunction

   function automatic logic signed [CB-1:0] rand_comp();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
         1: return CB'($signed($urandom_range(0, 16)) - 8);
         default: return CB'($urandom);
      endcase
   endfunction

   // driver: present the next pair at the falling edge, idle at random
   always @(negedge clock) begin
      if (!reset && start && !busy) begin
         expected_angles.push_back(predict_angle('{req_a_x, req_a_y, req_a_z,
                                                   req_b_x, req_b_y, req_b_z}));
         void'(pending_pairs.pop_front());
      end
      if (reset || drain_hold || pending_pairs.size() == 0 ||
          (quiet_left == 0 && $urandom_range(0, 99) < 28)) begin
         start <= 1'b0;
      end else begin
         start   <= 1'b1;
         req_a_x <= pending_pairs[0].ax; req_a_y <= pending_pairs[0].ay;
         req_a_z <= pending_pairs[0].az; req_b_x <= pending_pairs[0].bx;
         req_b_y <= pending_pairs[0].by; req_b_z <= pending_pairs[0].bz;
      end
      if (quiet_left > 0) quiet_left <= quiet_left - 1;
   end

   // monitor: compare each result transfer with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_angles.size() == 0) begin
            $error("unexpected result: angle %0d undefined %0b", rsp_angle, rsp_undefined);
            errors++;
         end else begin
            angle_type want;
            want = expected_angles.pop_front();
            if (rsp_angle !== want.angle) begin
               $error("angle: expected %0d, actual %0d", want.angle, rsp_angle);
               errors++;
            end
            if (rsp_undefined !== want.undef) begin
               $error("undefined: expected %0b, actual %0b", want.undef, rsp_undefined);
               errors++;
            end
         end
      end
   end

   // stimulus
   initial begin
      vec_pair_type p;
      logic signed [CB-1:0] ext[6];
      ext = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh0001, 16'shFFFF, 16'sh0100};
      // zero-length vectors on either side and both
      pending_pairs.push_back('{0, 0, 0, 16'sh0100, 0, 0});
      pending_pairs.push_back('{16'sh0100, 0, 0, 0, 0, 0});
      pending_pairs.push_back('{0, 0, 0, 0, 0, 0});
      // parallel, antiparallel and right angle
      pending_pairs.push_back('{16'sh0100, 16'sh0200, 16'sh0300, 16'sh0200, 16'sh0400, 16'sh0600});
      pending_pairs.push_back('{16'sh0100, 16'sh0200, 16'sh0300, -16'sh0100, -16'sh0200, -16'sh0300});
      pending_pairs.push_back('{16'sh0100, 0, 0, 0, 16'sh0100, 0});
      // full-scale extremes, where rounding can pass unity
      pending_pairs.push_back('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF});
      pending_pairs.push_back('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF});
      pending_pairs.push_back('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
      pending_pairs.push_back('{16'sh0001, 0, 0, 16'sh7FFF, 16'sh0001, 0});
      pending_pairs.push_back('{16'shFFFF, 16'sh0001, 0, 16'sh8000, 16'sh7FFF, 16'sh0001});
      for (int k = 0; k < 6; k++)
         pending_pairs.push_back('{ext[k], ext[(k+1)%6], ext[(k+2)%6],
                                   ext[(k+3)%6], ext[(k+4)%6], ext[(k+5)%6]});
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      for (int n = 0; n < 1340; n++) begin
         p = '{rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp()};
         // near-parallel pairs stress the clamp
         if ($urandom_range(0, 9) == 0) begin
            p.bx = p.ax + CB'($urandom_range(0, 2)); p.by = p.ay; p.bz = p.az;
            if ($urandom_range(0, 1)) begin
               p.bx = -p.bx; p.by = -p.by; p.bz = -p.bz;
            end
         end
         pending_pairs.push_back(p);
         if (n == 400) begin
            // stretch with no idling, then a full drain
            wait (pending_pairs.size() < 300);
            @(negedge clock) quiet_left <= 200;
            wait (pending_pairs.size() == 0);
            @(negedge clock) drain_hold <= 1'b1;
            wait (expected_angles.size() == 0);
            @(negedge clock) drain_hold <= 1'b0;
         end
      end
      wait (pending_pairs.size() == 0 && expected_angles.size() == 0);
      repeat (LATENCY + 20) @(posedge clock);
      stim_done = 1'b1;
      if (errors == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      if (!stim_done) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

endmodule
